// ===== rtl/aeskx_pkg.sv =====
package aeskx_pkg;

	// Number of round keys in the AES-128 schedule and the index of the final round key.
	localparam int unsigned NUM_ROUNDS = 11;
	localparam logic [3:0] LAST_ROUND = 4'(NUM_ROUNDS - 1);

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} status_t;

	// Standard AES forward S-box.
	localparam logic [7:0] SBOX [0:255] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// Round constant used to go from round r to round r + 1.
	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] c;
		unique case (r)
			4'd0: c = 8'h01;
			4'd1: c = 8'h02;
			4'd2: c = 8'h04;
			4'd3: c = 8'h08;
			4'd4: c = 8'h10;
			4'd5: c = 8'h20;
			4'd6: c = 8'h40;
			4'd7: c = 8'h80;
			4'd8: c = 8'h1b;
			4'd9: c = 8'h36;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/aeskx_datapath.sv =====
module aeskx_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aeskx_pkg::cmd_t      cmd,
	output aeskx_pkg::status_t   status,
	input  logic [63:0]          key_high,
	input  logic [63:0]          key_low,
	output logic [3:0]           round_index,
	output logic [127:0]         round_key
);

	logic [127:0] key_q;
	logic [3:0]   round_q;
	logic [31:0]  sub_w;
	logic [31:0]  t_w;
	logic [127:0] next_key;

	// SubWord on the last word, rotate by one byte, then add the round constant.
	always_comb begin
		sub_w = {aeskx_pkg::SBOX[key_q[127:120]], aeskx_pkg::SBOX[key_q[119:112]],
			aeskx_pkg::SBOX[key_q[111:104]], aeskx_pkg::SBOX[key_q[103:96]]};
		t_w = {sub_w[7:0], sub_w[31:8]} ^ {24'h000000, aeskx_pkg::rcon(round_q)};
		next_key[31:0]   = key_q[31:0] ^ t_w;
		next_key[63:32]  = key_q[63:32] ^ next_key[31:0];
		next_key[95:64]  = key_q[95:64] ^ next_key[63:32];
		next_key[127:96] = key_q[127:96] ^ next_key[95:64];
	end

	// Round key register; it also serves as the output register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= {key_high, key_low};
		end else if (cmd.step) begin
			key_q <= next_key;
		end
	end

	// Round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.load) begin
			round_q <= '0;
		end else if (cmd.step) begin
			round_q <= 4'(round_q + 4'd1);
		end
	end

	assign status.last = (round_q == aeskx_pkg::LAST_ROUND);
	assign round_index = round_q;
	assign round_key   = key_q;

	// A new key always starts at round zero.
	a_load_round0: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (round_q == 4'd0))
		else $error("round counter not cleared on key load");

	// A step advances exactly one round.
	a_step_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !cmd.load) |=> (round_q == 4'($past(round_q) + 4'd1)))
		else $error("round counter did not advance by one");

	// The schedule never steps past the final round.
	a_no_step_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !status.last)
		else $error("step requested on the final round");

endmodule

// ===== rtl/aeskx_ctrl.sv =====
module aeskx_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  aeskx_pkg::status_t   status,
	output aeskx_pkg::cmd_t      cmd
);

	aeskx_pkg::state_t state_q;
	aeskx_pkg::state_t state_d;
	logic              out_take;
	logic              in_take;

	// Handshake outputs and datapath commands.
	always_comb begin
		out_valid = (state_q == aeskx_pkg::ST_EMIT);
		out_take  = out_valid && !out_stall;
		// A new key may enter in the cycle the final round key is taken.
		in_stall  = !((state_q == aeskx_pkg::ST_IDLE) || (out_take && status.last));
		in_take   = in_valid && !in_stall;
		cmd.load  = in_take;
		cmd.step  = out_take && !status.last;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aeskx_pkg::ST_IDLE: begin
				if (in_take) begin
					state_d = aeskx_pkg::ST_EMIT;
				end
			end
			aeskx_pkg::ST_EMIT: begin
				if (out_take && status.last && !in_take) begin
					state_d = aeskx_pkg::ST_IDLE;
				end
			end
			default: state_d = aeskx_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aeskx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Accepting a key always leads to emitting round keys.
	a_load_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == aeskx_pkg::ST_EMIT))
		else $error("key accepted but no round keys follow");

	// A pending result is held until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	// Load and step never coincide.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step issued together");

endmodule

// ===== rtl/aes128_key_expansion.sv =====
// AES-128 key expansion. Each accepted item is one cipher key (key_low holds
// bytes 0..7, key_high bytes 8..15, byte 0 in the low bits); the block then
// delivers the eleven round keys of the encryption schedule, round 0 (the key
// itself) first, with last set on round 10. One round key is computed per
// cycle, while the output is not stalled, by a single round unit (four S-box
// lookups, rotate, round constant and the word XOR chain) feeding a 128-bit
// round key register that doubles as the output register, so a new key can be
// accepted in the cycle its predecessor's final round key is taken.
module aes128_key_expansion (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  round_index,
	output logic [63:0] round_key_high,
	output logic [63:0] round_key_low,
	output logic        last
);

	aeskx_pkg::cmd_t    cmd;
	aeskx_pkg::status_t status;
	logic [127:0]       round_key;

	aeskx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	aeskx_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.key_high    (key_high),
		.key_low     (key_low),
		.round_index (round_index),
		.round_key   (round_key)
	);

	assign round_key_high = round_key[127:64];
	assign round_key_low  = round_key[63:0];
	assign last           = status.last;

endmodule

// ===== bench/aes128_key_expansion_tb.sv =====
`timescale 1ns / 1ps

module aes128_key_expansion_tb;

	// Field polynomial of GF(2^8) and the S-box affine constant.
	localparam logic [7:0] GF_POLY = 8'h1b;
	localparam logic [7:0] AFFINE_C = 8'h63;
	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 30;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_key_t;

	typedef struct {
		logic [3:0] idx;
		logic [63:0] hi;
		logic [63:0] lo;
		logic last;
	} round_key_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] key_high = '0;
	logic [63:0] key_low = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] round_index;
	logic [63:0] round_key_high;
	logic [63:0] round_key_low;
	logic last;

	cipher_key_t key_q[$];
	round_key_t round_key_q[$];
	cipher_key_t next_key;
	round_key_t want;
	int send_idle_pct = 0;
	int rx_stall_pct = 0;
	logic hold_off = 1'b0;
	int errors = 0;

	aes128_key_expansion u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key_high(key_high),
		.key_low(key_low),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.round_index(round_index),
		.round_key_high(round_key_high),
		.round_key_low(round_key_low),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = xtime(a);
		end
		return p;
	endfunction

	// S-box built from first principles: the field inverse (x^254, zero maps to
	// zero) followed by the affine transform.
	function automatic logic [7:0] sbox_byte(input logic [7:0] x);
		logic [7:0] sq;
		logic [7:0] inv;
		logic [7:0] s;
		sq = x;
		inv = 8'h01;
		for (int i = 1; i < 8; i++) begin
			sq = gf_mul(sq, sq);
			inv = gf_mul(inv, sq);
		end
		s = inv ^ ((inv << 1) | (inv >> 7)) ^ ((inv << 2) | (inv >> 6))
			^ ((inv << 3) | (inv >> 5)) ^ ((inv << 4) | (inv >> 4)) ^ AFFINE_C;
		return s;
	endfunction

	// Expand one cipher key into its eleven round keys and queue them in order.
	task automatic expand_key(input logic [63:0] hi, input logic [63:0] lo);
		logic [31:0] w [4];
		logic [31:0] t;
		logic [7:0] rc;
		round_key_t rk;
		w[0] = lo[31:0];
		w[1] = lo[63:32];
		w[2] = hi[31:0];
		w[3] = hi[63:32];
		rc = RCON_FIRST;
		for (int r = 0; r < aeskx_pkg::NUM_ROUNDS; r++) begin
			if (r > 0) begin
				t = {sbox_byte(w[3][31:24]), sbox_byte(w[3][23:16]),
					sbox_byte(w[3][15:8]), sbox_byte(w[3][7:0])};
				t = {t[7:0], t[31:8]};
				t[7:0] ^= rc;
				rc = xtime(rc);
				w[0] ^= t;
				w[1] ^= w[0];
				w[2] ^= w[1];
				w[3] ^= w[2];
			end
			rk.idx = 4'(r);
			rk.hi = {w[3], w[2]};
			rk.lo = {w[1], w[0]};
			rk.last = (4'(r) == aeskx_pkg::LAST_ROUND);
			round_key_q.push_back(rk);
		end
	endtask

	// Key driver: predicts on each accepted item, holds a stalled item, and
	// otherwise offers the next pending key unless it chooses to idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			key_high <= '0;
			key_low <= '0;
		end else begin
			if (in_valid && !in_stall)
				expand_key(key_high, key_low);
			if (!(in_valid && in_stall)) begin
				if (key_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_key = key_q.pop_front();
					in_valid <= 1'b1;
					key_high <= next_key.hi;
					key_low <= next_key.lo;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Round key monitor: compares each accepted item with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (round_key_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected round key: idx %0d hi %h lo %h last %b",
							round_index, round_key_high, round_key_low, last);
				end else begin
					want = round_key_q.pop_front();
					if (round_index !== want.idx || round_key_high !== want.hi
						|| round_key_low !== want.lo || last !== want.last) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("mismatch: exp idx %0d hi %h lo %h last %b,",
								want.idx, want.hi, want.lo, want.last,
								" got idx %0d hi %h lo %h last %b",
								round_index, round_key_high, round_key_low, last);
					end
				end
			end
			out_stall <= hold_off || ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	// Wait until every queued key has been accepted and every round key seen.
	task automatic wait_drained();
		while (key_q.size() > 0 || in_valid || round_key_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic push_random(input int n);
		cipher_key_t k;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0: k.hi = '0;
				1: k.hi = '1;
				default: k.hi = {$urandom, $urandom};
			endcase
			case ($urandom_range(0, 7))
				0: k.lo = '0;
				1: k.lo = '1;
				default: k.lo = {$urandom, $urandom};
			endcase
			key_q.push_back(k);
		end
	endtask

	// Stimulus sequence and end of run.
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed keys: extremes, the standard test key, and boundary patterns.
		key_q.push_back('{64'h0, 64'h0});
		key_q.push_back('{'1, '1});
		key_q.push_back('{64'h3c4fcf098815f7ab, 64'ha6d2ae2816157e2b});
		key_q.push_back('{'1, 64'h0});
		key_q.push_back('{64'h0, '1});
		key_q.push_back('{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
		key_q.push_back('{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
		key_q.push_back('{64'h8000000000000000, 64'h0000000000000001});
		key_q.push_back('{64'h0000000000000001, 64'h8000000000000000});
		key_q.push_back('{64'hffffffff00000000, 64'h00000000ffffffff});
		key_q.push_back('{64'h0f0e0d0c0b0a0908, 64'h0706050403020100});
		key_q.push_back('{64'h7f7f7f7f7f7f7f7f, 64'h8080808080808080});
		wait_drained();

		// Back-to-back keys, with a long receiver hold-off so the block backs up.
		push_random(110);
		repeat (20) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
		wait_drained();

		// Sparse sender; each phase waits for everything to drain before the next.
		send_idle_pct <= 81;
		push_random(110);
		wait_drained();

		send_idle_pct <= 0;
		rx_stall_pct <= 81;
		push_random(110);
		wait_drained();

		send_idle_pct <= 12;
		rx_stall_pct <= 12;
		push_random(110);
		wait_drained();

		send_idle_pct <= 0;
		rx_stall_pct <= 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (round_key_q.size() > 0)
			errors++;
		if (errors == 0)
			$display("aes128_key_expansion_tb: done, clean");
		else
			$display("aes128_key_expansion_tb: done, errors");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#1000000;
		$display("aes128_key_expansion_tb: done, errors");
		$finish;
	end

endmodule
